### src/fasr_pkg.sv
// Shared types and width constants for the fraction add/subtract and reduce block.
package fasr_pkg;

	// Width of each input numerator and denominator.
	localparam int IN_WIDTH = 16;
	// Widths of the reduced result fields.
	localparam int NUM_W = 33;
	localparam int DEN_W = 32;
	// Width of one cross product; the signed sum of two of them takes one bit more.
	localparam int PROD_W = 2 * IN_WIDTH;
	// Width of a magnitude taken from the sum or the denominator product.
	localparam int MAG_W = PROD_W + 1;
	// Width of the shared add/subtract unit, with headroom for the sign of a difference.
	localparam int ALU_W = MAG_W + 2;
	// Width of the division step counter.
	localparam int CNT_W = $clog2(MAG_W + 1);

	// Operation codes carried in the kind field.
	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_SUB = 1'b1;

	// One input beat.
	typedef struct packed {
		logic                        kind;
		logic signed [IN_WIDTH-1:0]  first_num;
		logic signed [IN_WIDTH-1:0]  first_den;
		logic signed [IN_WIDTH-1:0]  second_num;
		logic signed [IN_WIDTH-1:0]  second_den;
	} cmd_t;

	// One result beat.
	typedef struct packed {
		logic signed [NUM_W-1:0] reduced_num;
		logic signed [DEN_W-1:0] reduced_den;
		logic                    error;
	} result_t;

endpackage

### src/fraction_add_sub_reduce.sv
// Top level: a/b +/- c/d reduced by the greatest common divisor, on one shared multiplier and adder.
// Steps: three products, the sum, the numerator magnitude, then the denominator magnitude; a zero
// denominator ends the item there with the error beat. Otherwise common factors of two are stripped,
// the binary gcd runs (halvings, swaps and subtractions), and two restoring divisions give the
// reduced numerator and denominator. One item at a time: busy is high until the result beat is out.
// The done strobe lasts one cycle and cannot be held off. arst_n clears the sequencer and strobe.
module fraction_add_sub_reduce
	import fasr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	typedef enum logic [3:0] {
		IDLE,
		MUL_P,
		MUL_Q,
		MUL_D,
		SUM,
		ABS_N,
		ABS_D,
		EVEN,
		GCD,
		DIV_N,
		FIX_N,
		DIV_D,
		FIX_D
	} state_t;

	state_t state_q;

	// Captured operands.
	logic                       kind_q;
	logic signed [IN_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;

	// Products, sum and magnitudes.
	logic signed [PROD_W-1:0]   p_q, q_q, dp_q;
	logic signed [PROD_W:0]     n_q;
	logic                       sn_q, sd_q;
	logic [MAG_W-1:0]           mn_q, md_q;
	logic [MAG_W-1:0]           a_q, b_q;

	// Divider registers.
	logic [MAG_W-1:0]           dvd_q;
	logic [MAG_W:0]             rem_q;
	logic [CNT_W-1:0]           cnt_q;

	// Output registers.
	result_t                    result_q;
	logic                       done_q;

	// Shared multiplier datapath.
	logic signed [IN_WIDTH-1:0] mul_x, mul_y;
	logic signed [PROD_W-1:0]   prod;

	// Shared add/subtract datapath.
	logic [ALU_W-1:0]           alu_a, alu_b, alu_y;
	logic                       alu_sub;
	logic                       alu_neg;
	logic [MAG_W:0]             rem_sh;

	// Multiplier operand selection for the three products.
	always_comb begin
		unique case (state_q)
			MUL_P: begin
				mul_x = an_q;
				mul_y = bd_q;
			end
			MUL_Q: begin
				mul_x = bn_q;
				mul_y = ad_q;
			end
			default: begin
				mul_x = ad_q;
				mul_y = bd_q;
			end
		endcase
	end

	assign prod = mul_x * mul_y;

	// Partial remainder shifted left by one dividend bit.
	assign rem_sh = {rem_q[MAG_W-1:0], dvd_q[MAG_W-1]};

	// Adder operand selection for each step of the sequence.
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		unique case (state_q)
			SUM: begin
				alu_a   = ALU_W'(p_q);
				alu_b   = ALU_W'(q_q);
				alu_sub = (kind_q == KIND_SUB);
			end
			ABS_N: alu_b = ALU_W'(n_q);
			ABS_D: alu_b = ALU_W'(dp_q);
			GCD: begin
				alu_a = ALU_W'(a_q);
				alu_b = ALU_W'(b_q);
			end
			DIV_N, DIV_D: begin
				alu_a = ALU_W'(rem_sh);
				alu_b = ALU_W'(b_q);
			end
			FIX_N, FIX_D: alu_b = ALU_W'(dvd_q);
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	assign alu_y   = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
	assign alu_neg = alu_y[ALU_W-1];

	// Sequencer, datapath registers and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (start) begin
						kind_q  <= cmd.kind;
						an_q    <= cmd.first_num;
						ad_q    <= cmd.first_den;
						bn_q    <= cmd.second_num;
						bd_q    <= cmd.second_den;
						state_q <= MUL_P;
					end
				end
				MUL_P: begin
					p_q     <= prod;
					state_q <= MUL_Q;
				end
				MUL_Q: begin
					q_q     <= prod;
					state_q <= MUL_D;
				end
				MUL_D: begin
					dp_q    <= prod;
					state_q <= SUM;
				end
				SUM: begin
					n_q     <= alu_y[PROD_W:0];
					state_q <= ABS_N;
				end
				ABS_N: begin
					// Magnitude of the numerator feeds both the gcd and the divider.
					sn_q    <= n_q[PROD_W];
					mn_q    <= n_q[PROD_W] ? alu_y[MAG_W-1:0] : MAG_W'(unsigned'(n_q));
					a_q     <= n_q[PROD_W] ? alu_y[MAG_W-1:0] : MAG_W'(unsigned'(n_q));
					state_q <= ABS_D;
				end
				ABS_D: begin
					if (dp_q == '0) begin
						// Zero denominator: flag it and give zero fields.
						result_q.reduced_num <= '0;
						result_q.reduced_den <= '0;
						result_q.error       <= 1'b1;
						done_q               <= 1'b1;
						state_q              <= IDLE;
					end else begin
						sd_q    <= dp_q[PROD_W-1];
						md_q    <= dp_q[PROD_W-1] ? alu_y[MAG_W-1:0]
							: MAG_W'(unsigned'(dp_q));
						b_q     <= dp_q[PROD_W-1] ? alu_y[MAG_W-1:0]
							: MAG_W'(unsigned'(dp_q));
						state_q <= EVEN;
					end
				end
				EVEN: begin
					// Strip common factors of two from the operands and from the values
					// to divide, so the odd gcd that follows divides both exactly.
					if (!a_q[0] && !b_q[0]) begin
						a_q  <= a_q >> 1;
						b_q  <= b_q >> 1;
						mn_q <= mn_q >> 1;
						md_q <= md_q >> 1;
					end else begin
						state_q <= GCD;
					end
				end
				GCD: begin
					// Binary gcd: one halving, swap or halved difference per cycle.
					priority if (a_q == '0) begin
						dvd_q   <= mn_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= DIV_N;
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (alu_neg) begin
						a_q <= b_q;
						b_q <= a_q;
					end else begin
						a_q <= alu_y[MAG_W:1];
					end
				end
				DIV_N, DIV_D: begin
					// Restoring division: one quotient bit per cycle.
					rem_q <= alu_neg ? rem_sh : alu_y[MAG_W:0];
					dvd_q <= {dvd_q[MAG_W-2:0], ~alu_neg};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MAG_W - 1)) begin
						state_q <= (state_q == DIV_N) ? FIX_N : FIX_D;
					end
				end
				FIX_N: begin
					// Restore the numerator sign, then start on the denominator.
					result_q.reduced_num <= NUM_W'(sn_q ? alu_y[MAG_W-1:0] : dvd_q);
					dvd_q                <= md_q;
					rem_q                <= '0;
					cnt_q                <= '0;
					state_q              <= DIV_D;
				end
				FIX_D: begin
					result_q.reduced_den <= DEN_W'(sd_q ? alu_y[MAG_W-1:0] : dvd_q);
					result_q.error       <= 1'b0;
					done_q               <= 1'b1;
					state_q              <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign busy   = (state_q != IDLE);
	assign done   = done_q;
	assign result = result_q;

	// An accepted beat makes the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after an accepted beat");

	// The result strobe is never asserted in consecutive cycles.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// An error beat carries zero fields; a good beat never has a zero denominator.
	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.error ? (result.reduced_num == '0 && result.reduced_den == '0)
			: (result.reduced_den != '0)))
		else $error("result fields disagree with the error flag");

	// The gcd loop never runs with a zero second operand.
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == GCD |-> b_q != '0)
		else $error("gcd operand became zero");

endmodule
